// ===== hw/rtl/lsf_pkg.sv =====
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared types and constants of the 3x3 Laplacian sharpening filter.
// ----------------------------------------------------------------------------
package lsf_pkg;

    localparam int PIX_W        = 8;
    localparam int CFG_WIDTH_W  = 12;
    localparam int CFG_HEIGHT_W = 13;
    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_EIGHT_NB     = 2'd2;

    localparam logic [CFG_WIDTH_W-1:0]  RST_FRAME_WIDTH  = 12'd640;
    localparam logic [CFG_HEIGHT_W-1:0] RST_FRAME_HEIGHT = 13'd480;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // output queue
    localparam int OFIFO_DEPTH = 4;
    localparam int OFIFO_PTR_W = 2;
    localparam int OFIFO_CNT_W = 3;

    // where the result value of a transaction comes from
    typedef enum logic [2:0] {
        KIND_LAST_UP,
        KIND_PASS,
        KIND_SHARP,
        KIND_DRAIN_UP,
        KIND_DRAIN_MID
    } t_kind;

    // decoded transaction, sequencer to datapath
    typedef struct packed {
        logic             valid;
        logic             shift;
        logic             result;
        logic             last;
        logic             at_wlast;
        t_kind            kind;
        logic [PIX_W-1:0] pixel;
    } t_issue;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_result;

    // results in flight, datapath to top
    typedef struct packed {
        logic s1_res;
        logic s2_res;
    } t_pipe_stat;

endpackage

// ===== hw/rtl/lsf_ram.sv =====
// ----------------------------------------------------------------------------
// lsf_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/lsf_seq.sv =====
// ----------------------------------------------------------------------------
// lsf_seq
// Input and output position counters; decodes each accepted transaction.
// ----------------------------------------------------------------------------
module lsf_seq #(
    parameter int AW = 11,
    parameter int RW = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic                      i_cmd,
    input  logic [lsf_pkg::PIX_W-1:0] i_pixel,
    input  logic [AW-1:0]             i_w_last,
    input  logic [RW-1:0]             i_h_last,
    input  logic                      i_restart,
    output lsf_pkg::t_issue           o_issue,
    output logic [AW-1:0]             o_rd_addr
);

    import lsf_pkg::*;

    logic [AW-1:0] r_ic, n_ic;
    logic [RW-1:0] r_ir, n_ir;
    logic [AW-1:0] r_oc, n_oc;
    logic [RW-1:0] r_or, n_or;
    logic          r_in_done, n_in_done;

    logic is_pix;
    logic is_drn;
    logic col_last;
    logic row_last;
    logic ocol_last;
    logic orow_last;
    logic row_ge2;
    logic produced;

    always_comb begin
        is_pix    = i_accept && (i_cmd == CMD_PIXEL) && !r_in_done;
        is_drn    = i_accept && (i_cmd == CMD_DRAIN) && r_in_done;
        col_last  = (r_ic == i_w_last);
        row_last  = (r_ir == i_h_last);
        ocol_last = (r_oc == i_w_last);
        orow_last = (r_or == i_h_last);
        row_ge2   = |r_ir[RW-1:1];
        produced  = row_ge2 || (r_ir[0] && (r_ic != '0));
    end

    always_comb begin
        n_ic      = r_ic;
        n_ir      = r_ir;
        n_oc      = r_oc;
        n_or      = r_or;
        n_in_done = r_in_done;
        o_issue   = '0;
        o_issue.kind  = KIND_PASS;
        o_issue.pixel = i_pixel;
        o_rd_addr = r_ic;

        if (is_pix) begin
            o_issue.valid    = 1'b1;
            o_issue.shift    = 1'b1;
            o_issue.result   = produced;
            o_issue.at_wlast = col_last;
            if (r_ic == '0) begin
                o_issue.kind = KIND_LAST_UP;
            end else if (!row_ge2 || (r_ic == AW'(1))) begin
                o_issue.kind = KIND_PASS;
            end else begin
                o_issue.kind = KIND_SHARP;
            end

            if (col_last) begin
                n_ic = '0;
                if (row_last) begin
                    n_in_done = 1'b1;
                end else begin
                    n_ir = r_ir + RW'(1);
                end
            end else begin
                n_ic = r_ic + AW'(1);
            end

            if (produced) begin
                if (ocol_last) begin
                    n_oc = '0;
                    n_or = r_or + RW'(1);
                end else begin
                    n_oc = r_oc + AW'(1);
                end
            end
        end else if (is_drn) begin
            o_rd_addr      = r_oc;
            o_issue.valid  = 1'b1;
            o_issue.result = 1'b1;
            o_issue.kind   = orow_last ? KIND_DRAIN_MID : KIND_DRAIN_UP;
            o_issue.last   = orow_last && ocol_last;
            if (orow_last && ocol_last) begin
                // frame complete: start over
                n_ic      = '0;
                n_ir      = '0;
                n_oc      = '0;
                n_or      = '0;
                n_in_done = 1'b0;
            end else if (ocol_last) begin
                n_oc = '0;
                n_or = r_or + RW'(1);
            end else begin
                n_oc = r_oc + AW'(1);
            end
        end

        if (i_restart) begin
            n_ic      = '0;
            n_ir      = '0;
            n_oc      = '0;
            n_or      = '0;
            n_in_done = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ic      <= '0;
            r_ir      <= '0;
            r_oc      <= '0;
            r_or      <= '0;
            r_in_done <= 1'b0;
        end else begin
            r_ic      <= n_ic;
            r_ir      <= n_ir;
            r_oc      <= n_oc;
            r_or      <= n_or;
            r_in_done <= n_in_done;
        end
    end

endmodule

// ===== hw/rtl/lsf_kernel.sv =====
// ----------------------------------------------------------------------------
// lsf_kernel
// Line buffer read-modify-write, 3x3 window and Laplacian sharpening.
// Stage 1 takes the line buffer data, writes back and shifts the window;
// stage 2 evaluates the kernel and hands the result to the output queue.
// ----------------------------------------------------------------------------
module lsf_kernel #(
    parameter int AW = 11
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lsf_pkg::t_issue           i_issue,
    input  logic [AW-1:0]             i_rd_addr,
    input  logic                      i_eight_nb,
    input  logic [lsf_pkg::PIX_W-1:0] i_top_rd,
    input  logic [lsf_pkg::PIX_W-1:0] i_mid_rd,
    output logic                      o_we,
    output logic [AW-1:0]             o_waddr,
    output logic [lsf_pkg::PIX_W-1:0] o_up_wdata,
    output logic [lsf_pkg::PIX_W-1:0] o_mid_wdata,
    output logic                      o_push,
    output lsf_pkg::t_result          o_push_data,
    output lsf_pkg::t_pipe_stat       o_stat
);

    import lsf_pkg::*;

    localparam int SUM_W   = PIX_W + 3;
    localparam int ACC_W   = PIX_W + 5;
    localparam int K_FOUR  = 4;
    localparam int K_EIGHT = 8;

    // stage 1
    t_issue           r_s1, n_s1;
    logic [AW-1:0]    r_s1_addr;
    logic             r_fwd, n_fwd;
    logic [PIX_W-1:0] r_fwd_top;
    logic [PIX_W-1:0] r_fwd_mid;
    logic [PIX_W-1:0] r_last_up;
    logic [PIX_W-1:0] r_win [3][3];

    // stage 2
    logic             r_s2_valid, n_s2_valid;
    logic             r_s2_last;
    t_kind            r_s2_kind;
    logic [PIX_W-1:0] r_s2_direct;

    logic [PIX_W-1:0] top_eff;
    logic [PIX_W-1:0] mid_eff;
    logic [PIX_W-1:0] direct;
    logic [PIX_W-1:0] centre;
    logic [SUM_W-1:0] sum4;
    logic [SUM_W-1:0] sum8;
    logic [ACC_W-1:0] acc;
    logic [PIX_W-1:0] sharp;
    logic [PIX_W-1:0] value;

    // ---- stage 1: read-modify-write of the line buffers ----
    always_comb begin
        top_eff     = r_fwd ? r_fwd_top : i_top_rd;
        mid_eff     = r_fwd ? r_fwd_mid : i_mid_rd;
        o_we        = r_s1.valid && r_s1.shift;
        o_waddr     = r_s1_addr;
        o_up_wdata  = mid_eff;
        o_mid_wdata = r_s1.pixel;
        // the read issued now sees the old entry if stage 1 writes it this cycle
        n_fwd       = i_issue.valid && o_we && (i_rd_addr == r_s1_addr);
        n_s1        = i_issue;
        n_s2_valid  = r_s1.valid && r_s1.result;

        case (r_s1.kind)
            KIND_LAST_UP:   direct = r_last_up;
            KIND_DRAIN_UP:  direct = top_eff;
            KIND_DRAIN_MID: direct = mid_eff;
            default:        direct = mid_eff;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1       <= '0;
            r_fwd      <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1       <= n_s1;
            r_fwd      <= n_fwd;
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr   <= i_rd_addr;
        r_fwd_top   <= mid_eff;
        r_fwd_mid   <= r_s1.pixel;
        r_s2_last   <= r_s1.last;
        r_s2_kind   <= r_s1.kind;
        r_s2_direct <= direct;
        if (o_we && r_s1.at_wlast) begin
            r_last_up <= mid_eff;
        end
        if (o_we) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= top_eff;
            r_win[1][2] <= mid_eff;
            r_win[2][2] <= r_s1.pixel;
        end
    end

    // ---- stage 2: kernel on the window ----
    always_comb begin
        centre = r_win[1][1];
        sum4 = SUM_W'(r_win[0][1]) + SUM_W'(r_win[2][1]) +
               SUM_W'(r_win[1][0]) + SUM_W'(r_win[1][2]);
        sum8 = sum4 + SUM_W'(r_win[0][0]) + SUM_W'(r_win[0][2]) +
               SUM_W'(r_win[2][0]) + SUM_W'(r_win[2][2]);
        if (i_eight_nb) begin
            acc = ACC_W'(centre) + ACC_W'(centre) * ACC_W'(K_EIGHT) - ACC_W'(sum8);
        end else begin
            acc = ACC_W'(centre) + ACC_W'(centre) * ACC_W'(K_FOUR) - ACC_W'(sum4);
        end
        // clamp: sign bit set -> 0, anything above 8 bits -> 255
        if (acc[ACC_W-1]) begin
            sharp = '0;
        end else if (|acc[ACC_W-2:PIX_W]) begin
            sharp = '1;
        end else begin
            sharp = acc[PIX_W-1:0];
        end

        case (r_s2_kind)
            KIND_PASS:  value = centre;
            KIND_SHARP: value = sharp;
            default:    value = r_s2_direct;
        endcase

        o_push            = r_s2_valid;
        o_push_data.pixel = value;
        o_push_data.last  = r_s2_last;
        o_stat.s1_res     = r_s1.valid && r_s1.result;
        o_stat.s2_res     = r_s2_valid;
    end

endmodule

// ===== hw/rtl/lsf_ofifo.sv =====
// ----------------------------------------------------------------------------
// lsf_ofifo
// Small output queue that decouples the pipeline from the receiver's stall.
// ----------------------------------------------------------------------------
module lsf_ofifo (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  lsf_pkg::t_result                i_data,
    input  logic                            i_pop,
    output lsf_pkg::t_result                o_data,
    output logic [lsf_pkg::OFIFO_CNT_W-1:0] o_count
);

    import lsf_pkg::*;

    t_result                r_mem [OFIFO_DEPTH];
    logic [OFIFO_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [OFIFO_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [OFIFO_CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + OFIFO_PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + OFIFO_PTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + OFIFO_CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - OFIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// ===== hw/rtl/laplacian_sharpen_filter_3x3.sv =====
// ----------------------------------------------------------------------------
// laplacian_sharpen_filter_3x3
// 3x3 Laplacian sharpening of an 8-bit grey pixel stream in raster order.
//
// Input channel (i_valid / o_stall): i_cmd = 0 carries a pixel in
// i_pixel_in, i_cmd = 1 is a drain tick that releases one pending result
// once the whole frame is in. Output channel (o_valid / i_stall) carries the
// sharpened pixel and o_frame_last on the final pixel of the frame.
// Throughput is one transaction per clock while o_stall is low; the two line
// buffers each do one read and one write per cycle. A result released by a
// transaction goes through stage 1, stage 2 and the output queue before it
// shows on o_valid; in pixel terms results trail the input by one row plus one pixel.
// A 4-entry output queue absorbs receiver stalls; o_stall rises once the
// queued results plus the results still in the pipeline reach 4, and comes
// from registers only.
// Reset sets 640 x 480, four-neighbour kernel, and clears all counters and
// the pipeline; line buffer contents are not cleared. Writing frame_width or
// frame_height restarts the frame; write registers only while idle.
// ----------------------------------------------------------------------------
module laplacian_sharpen_filter_3x3 #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_cmd,
    input  logic [lsf_pkg::PIX_W-1:0]      i_pixel_in,
    // output channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [lsf_pkg::PIX_W-1:0]      o_pixel_out,
    output logic                           o_frame_last,
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lsf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lsf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lsf_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    import lsf_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WX = (CFG_WIDTH_W > AW) ? CFG_WIDTH_W : AW;
    localparam int HX = (CFG_HEIGHT_W > RW) ? CFG_HEIGHT_W : RW;

    logic [CFG_WIDTH_W-1:0]  r_frame_width, n_frame_width;
    logic [CFG_HEIGHT_W-1:0] r_frame_height, n_frame_height;
    logic                    r_eight_nb, n_eight_nb;

    logic                   cfg_wr;
    logic                   restart;
    logic [WX-1:0]          fw_m1;
    logic [HX-1:0]          fh_m1;
    logic [AW-1:0]          w_last;
    logic [RW-1:0]          h_last;
    logic                   accept;
    t_issue                 issue;
    logic [AW-1:0]          rd_addr;
    logic                   we;
    logic [AW-1:0]          waddr;
    logic [PIX_W-1:0]       up_wdata;
    logic [PIX_W-1:0]       mid_wdata;
    logic [PIX_W-1:0]       top_rd;
    logic [PIX_W-1:0]       mid_rd;
    logic                   push;
    t_result                push_data;
    t_pipe_stat             stat;
    t_result                head;
    logic [OFIFO_CNT_W-1:0] q_count;
    logic [OFIFO_CNT_W-1:0] reserved;

    // ---- register port ----
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        n_frame_width  = r_frame_width;
        n_frame_height = r_frame_height;
        n_eight_nb     = r_eight_nb;
        restart        = 1'b0;
        if (cfg_wr) begin
            case (paddr[3:2])
                REG_FRAME_WIDTH: begin
                    n_frame_width = pwdata[CFG_WIDTH_W-1:0];
                    restart       = 1'b1;
                end
                REG_FRAME_HEIGHT: begin
                    n_frame_height = pwdata[CFG_HEIGHT_W-1:0];
                    restart        = 1'b1;
                end
                REG_EIGHT_NB: begin
                    n_eight_nb = pwdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(r_frame_height);
            REG_EIGHT_NB:     prdata = APB_DATA_W'(r_eight_nb);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_eight_nb     <= 1'b0;
        end else begin
            r_frame_width  <= n_frame_width;
            r_frame_height <= n_frame_height;
            r_eight_nb     <= n_eight_nb;
        end
    end

    // last column and row index; zero counts as one, oversize clamps to max
    always_comb begin
        fw_m1 = WX'(r_frame_width) - WX'(1);
        fh_m1 = HX'(r_frame_height) - HX'(1);
        if (r_frame_width == '0) begin
            w_last = '0;
        end else if (fw_m1 > WX'(MAX_WIDTH - 1)) begin
            w_last = AW'(MAX_WIDTH - 1);
        end else begin
            w_last = fw_m1[AW-1:0];
        end
        if (r_frame_height == '0) begin
            h_last = '0;
        end else if (fh_m1 > HX'(MAX_HEIGHT - 1)) begin
            h_last = RW'(MAX_HEIGHT - 1);
        end else begin
            h_last = fh_m1[RW-1:0];
        end
    end

    // ---- flow control ----
    assign reserved = q_count + OFIFO_CNT_W'(stat.s1_res) + OFIFO_CNT_W'(stat.s2_res);
    assign o_stall  = (reserved >= OFIFO_CNT_W'(OFIFO_DEPTH));
    assign accept   = i_valid && !o_stall;

    lsf_seq #(
        .AW (AW),
        .RW (RW)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_cmd     (i_cmd),
        .i_pixel   (i_pixel_in),
        .i_w_last  (w_last),
        .i_h_last  (h_last),
        .i_restart (restart),
        .o_issue   (issue),
        .o_rd_addr (rd_addr)
    );

    lsf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_upper (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (up_wdata),
        .i_raddr (rd_addr),
        .o_rdata (top_rd)
    );

    lsf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_middle (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (mid_wdata),
        .i_raddr (rd_addr),
        .o_rdata (mid_rd)
    );

    lsf_kernel #(
        .AW (AW)
    ) u_kernel (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (issue),
        .i_rd_addr   (rd_addr),
        .i_eight_nb  (r_eight_nb),
        .i_top_rd    (top_rd),
        .i_mid_rd    (mid_rd),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_up_wdata  (up_wdata),
        .o_mid_wdata (mid_wdata),
        .o_push      (push),
        .o_push_data (push_data),
        .o_stat      (stat)
    );

    lsf_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (o_valid && !i_stall),
        .o_data  (head),
        .o_count (q_count)
    );

    assign o_valid      = (q_count != '0);
    assign o_pixel_out  = head.pixel;
    assign o_frame_last = head.last;

endmodule
